// ===== rtl/core/stxr_pkg.sv =====
// Shared types and constants for the serial transmit ring with FIFO credit.
// Used by stxr_ring and serial_tx_ring_with_fifo_credit_unit; no dependencies.
`default_nettype none

package stxr_pkg;

	// Configuration register indexes (byte address bit 2)
	localparam logic [0:0] REG_FIFO_DEPTH = 1'b0;
	localparam logic [0:0] REG_SPIN_LIMIT = 1'b1;

	// Reset values of the configuration registers
	localparam logic [4:0]  FIFO_DEPTH_RST = 5'd16;
	localparam logic [15:0] SPIN_LIMIT_RST = 16'hFFFF;

	// Ring control for one request
	typedef struct packed {
		logic       push;
		logic       pop;
		logic       flush;
		logic [7:0] wr_data;
	} ring_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/serial_tx_ring_with_fifo_credit_unit.sv =====
// Top level: UART transmit byte ring with FIFO credit, stuck detection and counters.
// Depends on stxr_pkg and stxr_ring.
//
// Usage:
//  A request is taken at a rising edge with start high and busy low; busy stays
//  low, so one request per cycle is taken back to back. func selects a push
//  (data_byte enters the ring, or is dropped when the ring is full) or a poll
//  (wait_allowed, thr_empty sampled; at most one byte leaves).
//  The result appears in the cycle after the request is taken, for exactly one
//  cycle, marked by done: the ring store has a registered read port, and the
//  byte read for a poll is shown from that port's output register. All other
//  result fields come from state written at the request edge.
//  Throughput: one request per cycle.
//  The receiver cannot stall; results are shown once and not held.
//  Configuration: APB registers fifo_depth at 0x0 and spin_limit at 0x4, written
//  while the block is idle. pready is always high.
//  Reset: indexes, credit, stuck mark, spin counts and counters clear; fifo_depth
//  returns to 16 and spin_limit to 65535. Ring contents are not cleared, no
//  clearing pass is needed.
`default_nettype none

module serial_tx_ring_with_fifo_credit_unit #(
	parameter int RING_DEPTH     = 4096,
	parameter int MAX_FIFO_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [7:0]  data_byte,
	input  wire logic        wait_allowed,
	input  wire logic        thr_empty,
	// result channel
	output logic             done,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic             push_accepted,
	output logic [12:0]      queued,
	output logic             stuck,
	output logic [31:0]      dropped_total,
	output logic [31:0]      backpressure_total,
	output logic [15:0]      spins_peak,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int RW = $clog2(MAX_FIFO_DEPTH + 1);

	logic [4:0]    fifo_depth_q;
	logic [15:0]   spin_limit_q;
	logic [RW-1:0] room_q;
	logic          stuck_q;
	logic [15:0]   spin_q;
	logic [15:0]   peak_q;
	logic [31:0]   drop_q;
	logic [31:0]   full_q;
	logic          done_q;
	logic          tx_valid_q;
	logic          acc_q;

	logic                accept;
	logic                is_push;
	logic                is_poll;
	logic                has_bytes;
	logic                can_push;
	logic                room_zero;
	logic                send;
	logic                load;
	logic                wait_poll;
	logic                give_up;
	logic [15:0]         spin_inc;
	logic [RW-1:0]       credit;
	logic [32:0]         drop_sum;
	logic [CW-1:0]       count;
	logic [7:0]          rd_data;
	logic                cfg_wr;
	stxr_pkg::ring_ctl_t ring_ctl;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Decode the request against the current ring and credit state
	assign is_push   = accept && (func == 1'b0);
	assign is_poll   = accept && (func == 1'b1);
	assign has_bytes = (count != '0);
	assign can_push  = (count < CW'(RING_DEPTH));
	assign room_zero = (room_q == '0);
	assign send      = is_poll && has_bytes && (!room_zero || thr_empty);
	assign load      = is_poll && has_bytes && room_zero && thr_empty;
	assign wait_poll = is_poll && has_bytes && room_zero && !thr_empty && wait_allowed;
	assign spin_inc  = spin_q + 16'd1;
	assign give_up   = wait_poll && (stuck_q || (spin_inc >= spin_limit_q));
	assign drop_sum  = {1'b0, drop_q} + 33'(count);

	// Clamp the configured depth to a usable credit
	always_comb begin
		if (fifo_depth_q == '0) begin
			credit = RW'(1);
		end else if (32'(fifo_depth_q) > 32'(MAX_FIFO_DEPTH)) begin
			credit = RW'(MAX_FIFO_DEPTH);
		end else begin
			credit = RW'(fifo_depth_q);
		end
	end

	// Drive the ring
	always_comb begin
		ring_ctl.push    = is_push && can_push;
		ring_ctl.pop     = send;
		ring_ctl.flush   = give_up;
		ring_ctl.wr_data = data_byte;
	end

	stxr_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.count  (count),
		.rd_data(rd_data)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_depth_q <= stxr_pkg::FIFO_DEPTH_RST;
			spin_limit_q <= stxr_pkg::SPIN_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				stxr_pkg::REG_FIFO_DEPTH: fifo_depth_q <= pwdata[4:0];
				stxr_pkg::REG_SPIN_LIMIT: spin_limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read mux
	always_comb begin
		unique case (paddr[2])
			stxr_pkg::REG_FIFO_DEPTH: prdata = 32'(fifo_depth_q);
			stxr_pkg::REG_SPIN_LIMIT: prdata = 32'(spin_limit_q);
			default:                  prdata = '0;
		endcase
	end

	// Credit, stuck mark, spin tracking and saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q  <= '0;
			stuck_q <= 1'b0;
			spin_q  <= '0;
			peak_q  <= '0;
			drop_q  <= '0;
			full_q  <= '0;
		end else begin
			if (is_push && !can_push) begin
				if (drop_q != '1) begin
					drop_q <= drop_q + 32'd1;
				end
				if (full_q != '1) begin
					full_q <= full_q + 32'd1;
				end
			end
			if (load) begin
				stuck_q <= 1'b0;
				if (spin_q > peak_q) begin
					peak_q <= spin_q;
				end
				spin_q <= '0;
				room_q <= credit - RW'(1);
			end else if (send) begin
				room_q <= room_q - RW'(1);
			end
			if (wait_poll) begin
				if (give_up) begin
					stuck_q <= 1'b1;
					spin_q  <= '0;
					drop_q  <= drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];
				end else begin
					spin_q <= spin_inc;
				end
			end
		end
	end

	// Result strobe and per-request flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			tx_valid_q <= 1'b0;
			acc_q      <= 1'b0;
		end else begin
			done_q     <= accept;
			tx_valid_q <= send;
			acc_q      <= is_push && can_push;
		end
	end

	assign done               = done_q;
	assign tx_valid           = tx_valid_q;
	assign tx_byte            = tx_valid_q ? rd_data : 8'd0;
	assign push_accepted      = acc_q;
	assign queued             = 13'(count);
	assign stuck              = stuck_q;
	assign dropped_total      = drop_q;
	assign backpressure_total = full_q;
	assign spins_peak         = peak_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept))
		else $error("result strobe does not follow the request");

	a_tx_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> done)
		else $error("byte handed out without a result strobe");

	a_push_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		push_accepted |-> !tx_valid)
		else $error("push and transmit in one result");

	a_stuck_empties: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stuck) |-> (queued == 13'd0))
		else $error("queue not discarded when marked stuck");

endmodule

`default_nettype wire

// ===== rtl/core/stxr_ring.sv =====
// Byte ring: synchronous store with registered read plus write/read indexes.
// Depends on stxr_pkg for the ring_ctl_t control struct.
`default_nettype none

module stxr_ring #(
	parameter int RING_DEPTH = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stxr_pkg::ring_ctl_t           ctl,
	output logic [$clog2(RING_DEPTH+1)-1:0]    count,
	output logic [7:0]                         rd_data
);

	localparam int IW = $clog2(2 * RING_DEPTH);
	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);

	logic [7:0]    mem [RING_DEPTH];
	logic [IW-1:0] wr_idx_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] wr_idx_nxt;
	logic [IW-1:0] rd_idx_nxt;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [IW:0]   diff;

	// Fold indexes (mod 2*depth) onto store addresses
	always_comb begin
		if (wr_idx_q >= IW'(RING_DEPTH)) begin
			wr_addr = AW'(wr_idx_q - IW'(RING_DEPTH));
		end else begin
			wr_addr = AW'(wr_idx_q);
		end
		if (rd_idx_q >= IW'(RING_DEPTH)) begin
			rd_addr = AW'(rd_idx_q - IW'(RING_DEPTH));
		end else begin
			rd_addr = AW'(rd_idx_q);
		end
	end

	// Advance indexes with wrap at twice the depth
	always_comb begin
		if (wr_idx_q == IW'(2 * RING_DEPTH - 1)) begin
			wr_idx_nxt = '0;
		end else begin
			wr_idx_nxt = wr_idx_q + IW'(1);
		end
		if (rd_idx_q == IW'(2 * RING_DEPTH - 1)) begin
			rd_idx_nxt = '0;
		end else begin
			rd_idx_nxt = rd_idx_q + IW'(1);
		end
	end

	// Fill level from the index distance
	always_comb begin
		diff = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
		if (wr_idx_q < rd_idx_q) begin
			diff = diff + (IW+1)'(2 * RING_DEPTH);
		end
		count = CW'(diff);
	end

	// Hold and advance indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else begin
			if (ctl.push) begin
				wr_idx_q <= wr_idx_nxt;
			end
			if (ctl.flush) begin
				rd_idx_q <= wr_idx_q;
			end else if (ctl.pop) begin
				rd_idx_q <= rd_idx_nxt;
			end
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_addr] <= ctl.wr_data;
		end
		if (ctl.pop) begin
			rd_data <= mem[rd_addr];
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(RING_DEPTH))
		else $error("ring fill level beyond depth");

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop))
		else $error("push and pop in the same request");

	a_no_flush_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flush |-> !ctl.pop)
		else $error("flush together with pop");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for serial_tx_ring_with_fifo_credit_unit: push and poll requests
// with random idling, APB register changes between phases, and a per-request ring model.
// Depends on stxr_pkg and the unit's RTL.

module testbench;

	localparam int RING_DEPTH  = 4096;
	localparam int MAX_CREDIT  = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 10;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POLL = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       wait_allowed;
		logic       thr_empty;
	} tx_request_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        push_accepted;
		logic [12:0] queued;
		logic        stuck;
		logic [31:0] dropped_total;
		logic [31:0] backpressure_total;
		logic [15:0] spins_peak;
	} tx_outcome_t;

	// Ring, credit and counter state, plus the outcomes still owed by the block
	class tx_ring_ledger;
		bit [7:0]    ring_bytes [RING_DEPTH];
		bit [12:0]   wr_ptr;
		bit [12:0]   rd_ptr;
		bit [4:0]    credit;
		bit          stuck_flag;
		bit [15:0]   spin_run;
		bit [15:0]   spin_peak;
		bit [31:0]   drop_count;
		bit [31:0]   full_count;
		bit [4:0]    depth_reg;
		bit [15:0]   limit_reg;
		tx_outcome_t pending_outcomes [$];
		int          mismatches;
		int          pushes;
		int          polls;
		int          bytes_sent;
		int          stuck_marks;
		int          fill_peak;

		function new();
			depth_reg = stxr_pkg::FIFO_DEPTH_RST;
			limit_reg = stxr_pkg::SPIN_LIMIT_RST;
		endfunction

		function void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("mismatch %s: expected %0h, got %0h", what, want, got);
			end
		endfunction

		function void configure(logic [0:0] idx, logic [31:0] value);
			if (idx == stxr_pkg::REG_FIFO_DEPTH) begin
				depth_reg = value[4:0];
			end else begin
				limit_reg = value[15:0];
			end
		endfunction

		function logic [31:0] register_value(logic [0:0] idx);
			return (idx == stxr_pkg::REG_FIFO_DEPTH) ? {27'd0, depth_reg} : {16'd0, limit_reg};
		endfunction

		function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
			bit [32:0] sum;
			sum = {1'b0, a} + {1'b0, b};
			return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		endfunction

		// Clamp the depth register into the credit one empty indication buys
		function bit [4:0] credit_size();
			bit [4:0] d;
			d = depth_reg;
			if (d == 0) d = 5'd1;
			if (d > MAX_CREDIT) d = 5'(MAX_CREDIT);
			return d;
		endfunction

		// Advance the ring for one accepted request and queue its outcome
		function void note_request(tx_request_t rq);
			tx_outcome_t want;
			bit [12:0]   fill;
			bit          sending;
			bit          give_up;
			want = '0;
			sending = 1'b0;
			fill = wr_ptr - rd_ptr;
			if (rq.func == FUNC_PUSH) begin
				pushes++;
				if (fill < RING_DEPTH) begin
					ring_bytes[wr_ptr % RING_DEPTH] = rq.data_byte;
					wr_ptr++;
					want.push_accepted = 1'b1;
				end else begin
					drop_count = sat_add(drop_count, 1);
					full_count = sat_add(full_count, 1);
				end
			end else begin
				polls++;
				if (fill != 0) begin
					if (credit != 0) begin
						sending = 1'b1;
					end else if (rq.thr_empty) begin
						// room found: clear the stuck mark and buy credit
						stuck_flag = 1'b0;
						if (spin_run > spin_peak) spin_peak = spin_run;
						spin_run = 16'd0;
						credit = credit_size();
						sending = 1'b1;
					end else if (rq.wait_allowed) begin
						give_up = stuck_flag;
						if (!give_up) begin
							spin_run = spin_run + 16'd1;
							give_up = spin_run >= limit_reg;
						end
						// give up: mark stuck and drop the whole queue
						if (give_up) begin
							stuck_flag = 1'b1;
							spin_run = 16'd0;
							drop_count = sat_add(drop_count, {19'd0, fill});
							rd_ptr = wr_ptr;
							stuck_marks++;
						end
					end
					if (sending) begin
						want.tx_valid = 1'b1;
						want.tx_byte = ring_bytes[rd_ptr % RING_DEPTH];
						rd_ptr++;
						credit--;
						bytes_sent++;
					end
				end
			end
			want.queued = wr_ptr - rd_ptr;
			want.stuck = stuck_flag;
			want.dropped_total = drop_count;
			want.backpressure_total = full_count;
			want.spins_peak = spin_peak;
			if (int'(want.queued) > fill_peak) fill_peak = int'(want.queued);
			pending_outcomes.push_back(want);
		endfunction

		// Compare one strobed result with the oldest outcome owed
		function void check_result(tx_outcome_t got);
			tx_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				flag_mismatch("result with no request", 0, 1);
				return;
			end
			want = pending_outcomes.pop_front();
			if (got.tx_valid !== want.tx_valid)
				flag_mismatch("tx_valid", want.tx_valid, got.tx_valid);
			if (got.tx_byte !== want.tx_byte)
				flag_mismatch("tx_byte", want.tx_byte, got.tx_byte);
			if (got.push_accepted !== want.push_accepted)
				flag_mismatch("push_accepted", want.push_accepted, got.push_accepted);
			if (got.queued !== want.queued)
				flag_mismatch("queued", want.queued, got.queued);
			if (got.stuck !== want.stuck)
				flag_mismatch("stuck", want.stuck, got.stuck);
			if (got.dropped_total !== want.dropped_total)
				flag_mismatch("dropped_total", want.dropped_total, got.dropped_total);
			if (got.backpressure_total !== want.backpressure_total)
				flag_mismatch("backpressure_total", want.backpressure_total,
					got.backpressure_total);
			if (got.spins_peak !== want.spins_peak)
				flag_mismatch("spins_peak", want.spins_peak, got.spins_peak);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [7:0]  data_byte;
	logic        wait_allowed;
	logic        thr_empty;
	logic        done;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        push_accepted;
	logic [12:0] queued;
	logic        stuck;
	logic [31:0] dropped_total;
	logic [31:0] backpressure_total;
	logic [15:0] spins_peak;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tx_ring_ledger ledger = new();
	bit            idle_on;
	int            reg_writes;
	int            cycle_count;

	serial_tx_ring_with_fifo_credit_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check each strobed result against the ledger
	always @(posedge clk) begin : result_monitor
		tx_outcome_t got;
		if (done === 1'b1) begin
			got.tx_valid = tx_valid;
			got.tx_byte = tx_byte;
			got.push_accepted = push_accepted;
			got.queued = queued;
			got.stuck = stuck;
			got.dropped_total = dropped_total;
			got.backpressure_total = backpressure_total;
			got.spins_peak = spins_peak;
			ledger.check_result(got);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles", cycle_count);
			$display("testbench: errors");
			$finish;
		end
	end

	// Pick an idle gap: mostly none or short, a few long
	function automatic int idle_cycles();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 96) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic tx_request_t make_request(logic f, logic [7:0] d, logic w, logic t);
		tx_request_t rq;
		rq.func = f;
		rq.data_byte = d;
		rq.wait_allowed = w;
		rq.thr_empty = t;
		return rq;
	endfunction

	// Present one request, hold it until taken, then maybe idle
	task automatic issue_request(tx_request_t rq);
		int gap;
		start <= 1'b1;
		func <= rq.func;
		data_byte <= rq.data_byte;
		wait_allowed <= rq.wait_allowed;
		thr_empty <= rq.thr_empty;
		do @(posedge clk); while (busy !== 1'b0);
		ledger.note_request(rq);
		gap = idle_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write one register once the block is idle, then read it back
	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		logic [31:0] keep_mask;
		logic [31:0] wdata;
		logic [31:0] want;
		start <= 1'b0;
		while (ledger.pending_outcomes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		// randomize the unused upper bits
		keep_mask = (idx == stxr_pkg::REG_FIFO_DEPTH) ? 32'h0000_001F : 32'h0000_FFFF;
		wdata = ($urandom() & ~keep_mask) | (value & keep_mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		ledger.configure(idx, wdata);
		reg_writes++;
		// read back with a fresh setup cycle
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		want = ledger.register_value(idx);
		if (prdata !== want) ledger.flag_mismatch("prdata", want, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random mix of pushes and polls
	task automatic run_mix(int count, int push_pct, int thr_pct);
		tx_request_t rq;
		for (int i = 0; i < count; i++) begin
			rq.func = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POLL;
			rq.data_byte = 8'($urandom_range(255));
			rq.wait_allowed = $urandom_range(99) < 75;
			rq.thr_empty = $urandom_range(99) < thr_pct;
			issue_request(rq);
		end
	endtask

	initial begin : stimulus
		int depth_plan [8];
		int limit_plan [8];
		int drain_wait;
		depth_plan = '{1, 16, 31, 17, 4, 2, 0, 9};
		limit_plan = '{1, 65535, 3, 2, 0, 6, 4, 12};
		depth_plan[7] = $urandom_range(31);
		limit_plan[7] = $urandom_range(10, 1);
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_PUSH;
		data_byte = 8'h00;
		wait_allowed = 1'b0;
		thr_empty = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: empty-ring polls, extreme bytes, spins, credit purchase
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b1, 1'b1));
		issue_request(make_request(FUNC_POLL, 8'hFF, 1'b1, 1'b0));
		issue_request(make_request(FUNC_PUSH, 8'h00, 1'b0, 1'b0));
		issue_request(make_request(FUNC_PUSH, 8'hFF, 1'b1, 1'b1));
		issue_request(make_request(FUNC_PUSH, 8'hA5, 1'b0, 1'b1));
		issue_request(make_request(FUNC_PUSH, 8'h5A, 1'b1, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b1, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b1, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b1));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b1, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b1));

		// Depth zero acts as one, zero spin limit: stuck on the first waiting poll
		write_reg(stxr_pkg::REG_FIFO_DEPTH, 32'd0);
		write_reg(stxr_pkg::REG_SPIN_LIMIT, 32'd0);
		while (ledger.credit != 0) begin
			issue_request(make_request(FUNC_PUSH, 8'($urandom_range(255)), 1'b0, 1'b0));
			issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b0));
		end
		issue_request(make_request(FUNC_PUSH, 8'h11, 1'b0, 1'b0));
		issue_request(make_request(FUNC_PUSH, 8'h22, 1'b0, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b1, 1'b0));
		issue_request(make_request(FUNC_PUSH, 8'h33, 1'b0, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b1, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b0));
		issue_request(make_request(FUNC_PUSH, 8'h44, 1'b0, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b1, 1'b1));
		issue_request(make_request(FUNC_PUSH, 8'h55, 1'b0, 1'b0));
		issue_request(make_request(FUNC_POLL, 8'h00, 1'b0, 1'b0));

		// Random phases over a spread of settings, some with no idling
		for (int p = 0; p < 8; p++) begin
			write_reg(stxr_pkg::REG_FIFO_DEPTH, depth_plan[p]);
			write_reg(stxr_pkg::REG_SPIN_LIMIT, limit_plan[p]);
			idle_on = (p % 3) != 0;
			run_mix(65, $urandom_range(65, 35), $urandom_range(50, 10));
		end

		// Build a deep queue under a high spin limit, then discard it
		write_reg(stxr_pkg::REG_FIFO_DEPTH, 32'd31);
		write_reg(stxr_pkg::REG_SPIN_LIMIT, 32'd65535);
		idle_on = 1'b1;
		run_mix(40, 90, 5);
		write_reg(stxr_pkg::REG_SPIN_LIMIT, 32'd1);
		run_mix(30, 20, 5);

		// Drain outstanding results, then allow for the registered result stage
		start <= 1'b0;
		drain_wait = 0;
		while (ledger.pending_outcomes.size() != 0 && drain_wait < 1000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (4) @(posedge clk);
		if (ledger.pending_outcomes.size() != 0)
			ledger.flag_mismatch("results never seen", 0, ledger.pending_outcomes.size());

		$display("covered %0d pushes and %0d polls, %0d bytes sent, %0d stuck marks, %0d reg writes",
			ledger.pushes, ledger.polls, ledger.bytes_sent, ledger.stuck_marks, reg_writes);
		$display("deepest fill %0d, bytes lost %0d, full-ring pushes %0d, mismatches %0d",
			ledger.fill_peak, ledger.drop_count, ledger.full_count, ledger.mismatches);
		if (ledger.mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
